FILE: design/cstp_pkg.sv
package cstp_pkg;

    localparam int MAX_FUNCS   = 256;
    localparam int STACK_DEPTH = 64;

    localparam int FUNC_W = $clog2(MAX_FUNCS);
    localparam int STK_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    localparam int REQ_W    = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    // True when a function id has a slot in the totals table
    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return (32'(id) < 32'(MAX_FUNCS));
    endfunction

endpackage

FILE: design/call_stack_exclusive_time_profiler.sv
// Channel | Ports                                        | Direction
// s_      | s_valid s_ready s_req_type s_func_id s_timestamp | in
// m_      | m_valid m_ready m_status m_total_time        | out
//
// Each item passes through accept (stack top read), credit setup
// (totals memory read), commit (one shared adder updates the total).
// The next item is accepted on the cycle after commit.
// Commit stalls while the output register still holds an untaken item.
// Reset clears the stack count and the valid bits of the totals table.
module call_stack_exclusive_time_profiler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cstp_pkg::REQ_W-1:0]        s_req_type,
    input  logic [cstp_pkg::ID_W-1:0]         s_func_id,
    input  logic [cstp_pkg::TIME_W-1:0]       s_timestamp,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cstp_pkg::STATUS_W-1:0]     m_status,
    output logic [cstp_pkg::TIME_W-1:0]       m_total_time
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CREDIT = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [cstp_pkg::ID_W-1:0]   stack_id_mem   [cstp_pkg::STACK_DEPTH];
    logic [cstp_pkg::TIME_W-1:0] stack_time_mem [cstp_pkg::STACK_DEPTH];
    logic [cstp_pkg::TIME_W-1:0] total_mem      [cstp_pkg::MAX_FUNCS];
    logic [cstp_pkg::MAX_FUNCS-1:0] total_vld_reg;

    logic [cstp_pkg::CNT_W-1:0]  cnt_reg;
    logic [cstp_pkg::REQ_W-1:0]  req_reg;
    logic [cstp_pkg::ID_W-1:0]   fid_reg;
    logic [cstp_pkg::TIME_W-1:0] t_reg;
    logic [cstp_pkg::ID_W-1:0]   top_id_reg;
    logic [cstp_pkg::TIME_W-1:0] top_time_reg;

    logic [cstp_pkg::FUNC_W-1:0]   addr_reg;
    logic [cstp_pkg::TIME_W-1:0]   delta_reg;
    logic                          credit_reg;
    logic                          rd_ok_reg;
    logic [cstp_pkg::STATUS_W-1:0] status_reg;
    logic [cstp_pkg::TIME_W-1:0]   tot_rd_reg;
    logic                          tot_vld_rd_reg;

    logic                          m_valid_reg;
    logic [cstp_pkg::STATUS_W-1:0] m_status_reg;
    logic [cstp_pkg::TIME_W-1:0]   m_total_time_reg;

    logic                          accept;
    logic                          commit;
    logic [cstp_pkg::STK_W-1:0]    top_idx;
    logic [cstp_pkg::STK_W-1:0]    below_idx;
    logic                          is_full;
    logic                          is_empty;
    logic [cstp_pkg::ID_W-1:0]     credit_id;
    logic [cstp_pkg::TIME_W-1:0]   delta_next;
    logic                          credit_next;
    logic                          rd_ok_next;
    logic [cstp_pkg::STATUS_W-1:0] status_next;
    logic [cstp_pkg::TIME_W:0]     sum_wide;
    logic [cstp_pkg::TIME_W-1:0]   old_total;
    logic [cstp_pkg::TIME_W-1:0]   new_total;
    logic [cstp_pkg::CNT_W-1:0]    top_cnt;
    logic [cstp_pkg::CNT_W-1:0]    below_cnt;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign commit       = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_total_time = m_total_time_reg;

    assign top_cnt   = cnt_reg - cstp_pkg::CNT_W'(1);
    assign below_cnt = cnt_reg - cstp_pkg::CNT_W'(2);
    assign top_idx   = top_cnt[cstp_pkg::STK_W-1:0];
    assign below_idx = below_cnt[cstp_pkg::STK_W-1:0];
    assign is_full   = (cnt_reg >= cstp_pkg::CNT_FULL);
    assign is_empty  = (cnt_reg == '0);

    // Decide the credit target, amount and status from the item and the stack top
    always_comb begin
        credit_id   = fid_reg;
        delta_next  = t_reg - top_time_reg;
        credit_next = 1'b0;
        rd_ok_next  = 1'b0;
        status_next = cstp_pkg::STS_OK;
        unique case (req_reg)
            cstp_pkg::REQ_START: begin
                credit_id = top_id_reg;
                if (is_full) begin
                    status_next = cstp_pkg::STS_OVERFLOW;
                end else begin
                    credit_next = !is_empty && cstp_pkg::id_in_range(top_id_reg);
                end
            end
            cstp_pkg::REQ_END: begin
                delta_next = t_reg - top_time_reg + cstp_pkg::TIME_W'(1);
                if (is_empty) begin
                    status_next = cstp_pkg::STS_UNDERFLOW;
                end else begin
                    credit_next = cstp_pkg::id_in_range(fid_reg);
                end
            end
            cstp_pkg::REQ_READ: begin
                rd_ok_next = cstp_pkg::id_in_range(fid_reg);
            end
            default: begin
            end
        endcase
    end

    // Shared adder with saturation
    assign old_total = tot_vld_rd_reg ? tot_rd_reg : '0;
    assign sum_wide  = {1'b0, old_total} + {1'b0, delta_reg};
    assign new_total = sum_wide[cstp_pkg::TIME_W] ? '1 : sum_wide[cstp_pkg::TIME_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_CREDIT;
            ST_CREDIT: state_next = ST_COMMIT;
            ST_COMMIT: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            total_vld_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (commit) begin
                if (credit_reg) begin
                    total_vld_reg[addr_reg] <= 1'b1;
                end
                if (status_reg == cstp_pkg::STS_OK) begin
                    if (req_reg == cstp_pkg::REQ_START) begin
                        cnt_reg <= cnt_reg + cstp_pkg::CNT_W'(1);
                    end else if (req_reg == cstp_pkg::REQ_END) begin
                        cnt_reg <= top_cnt;
                    end
                end
            end
        end
    end

    // Latch the item and read the stack top
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg      <= s_req_type;
            fid_reg      <= s_func_id;
            t_reg        <= s_timestamp;
            top_id_reg   <= stack_id_mem[top_idx];
            top_time_reg <= stack_time_mem[top_idx];
        end
    end

    // Read the total that will be credited or returned
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CREDIT) begin
            addr_reg       <= cstp_pkg::FUNC_W'(credit_id);
            delta_reg      <= delta_next;
            credit_reg     <= credit_next;
            rd_ok_reg      <= rd_ok_next;
            status_reg     <= status_next;
            tot_rd_reg     <= total_mem[cstp_pkg::FUNC_W'(credit_id)];
            tot_vld_rd_reg <= total_vld_reg[cstp_pkg::FUNC_W'(credit_id)];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg     <= status_reg;
            m_total_time_reg <= rd_ok_reg ? old_total : '0;
            if (credit_reg) begin
                total_mem[addr_reg] <= new_total;
            end
            if (status_reg == cstp_pkg::STS_OK) begin
                if (req_reg == cstp_pkg::REQ_START) begin
                    stack_id_mem[cnt_reg[cstp_pkg::STK_W-1:0]]   <= fid_reg;
                    stack_time_mem[cnt_reg[cstp_pkg::STK_W-1:0]] <= t_reg;
                end else if (req_reg == cstp_pkg::REQ_END &&
                             cnt_reg > cstp_pkg::CNT_W'(1)) begin
                    // resume the caller on the tick after the callee ends
                    stack_time_mem[below_idx] <= t_reg + cstp_pkg::TIME_W'(1);
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= cstp_pkg::CNT_FULL)
        else $error("stack count beyond depth");

    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_CREDIT)
        else $error("accepted item did not advance to credit");

    a_out_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("item presented without commit");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == cstp_pkg::STS_OVERFLOW) |-> is_full)
        else $error("overflow reported with room on stack");

    a_unf_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == cstp_pkg::STS_UNDERFLOW) |-> is_empty)
        else $error("underflow reported with entries on stack");

endmodule
